// ===== rtl/rhhm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash map package
// Shared types and constants for the hash map block.
// ----------------------------------------------------------------------------
package rhhm_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned OUT_W   = 3;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned CNT_W   = 11;

  localparam logic [LIMIT_W-1:0] KEY_LIMIT_RESET = 10'd768;

  localparam logic [OUT_W-1:0] OUT_INSERTED = 3'd0;
  localparam logic [OUT_W-1:0] OUT_UPDATED  = 3'd1;
  localparam logic [OUT_W-1:0] OUT_FULL     = 3'd2;
  localparam logic [OUT_W-1:0] OUT_FOUND    = 3'd3;
  localparam logic [OUT_W-1:0] OUT_ABSENT   = 3'd4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  ku;
    logic [KEY_W-1:0]  kl;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic              mode;
    entry_t            ent;
  } req_t;

  typedef struct packed {
    logic [OUT_W-1:0]  outcome;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
    logic [LEN_W-1:0]  len;
  } rsp_t;

endpackage

// ===== rtl/rhhm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash map channel
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface rhhm_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rhhm_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot memory
// Entry store and used-bit store, both with a registered read. The
// used bits are cleared by a pass over every slot after reset.
// ----------------------------------------------------------------------------
module rhhm_slot_mem
  import rhhm_pkg::*;
#(
  parameter int unsigned SLOTS = 1024,
  parameter int unsigned IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  output logic             clr_busy,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_ent,
  output logic             rd_used,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_ent,
  input  logic             wr_used
);

  entry_t           mem [SLOTS];
  logic             used_mem [SLOTS];
  logic             clr_r;
  logic [IDX_W-1:0] clr_idx_r;

  assign clr_busy = clr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    rd_ent <= mem[rd_idx];
  end

  // clearing pass after reset: one slot per cycle, over every slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(SLOTS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      used_mem[clr_idx_r] <= 1'b0;
    end else if (wr_en) begin
      used_mem[wr_idx] <= wr_used;
    end
    rd_used <= used_mem[rd_idx];
  end

endmodule

// ===== rtl/rhhm_probe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probe engine
// Walks the probe chain: read slot, compare, swap or write back.
// ----------------------------------------------------------------------------
module rhhm_probe
  import rhhm_pkg::*;
#(
  parameter int unsigned SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LIMIT_W-1:0] key_limit,
  rhhm_if.sink               req,
  rhhm_if.source             rsp
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned STP_W = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             mode_r;
  entry_t           carry_r, carry_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] dist_r, dist_nxt;
  logic [STP_W-1:0] steps_r, steps_nxt;
  logic             swapped_r, swapped_nxt;
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic             out_valid_r;
  rsp_t             out_r;

  entry_t           rd_ent;
  logic             rd_used;
  logic             wr_en, wr_used;
  entry_t           wr_ent;
  logic             clr_busy;

  logic             same, cap, less, last, fin;
  logic [IDX_W-1:0] od;
  rsp_t             res;

  rhhm_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk, .rst_n, .clr_busy,
    .rd_idx(idx_r), .rd_ent, .rd_used,
    .wr_en, .wr_idx(idx_r), .wr_ent, .wr_used
  );

  assign req.ready = (state_r == ST_IDLE) && !out_valid_r && !clr_busy;
  assign rsp.valid = out_valid_r;
  assign rsp.data  = out_r;

  always_comb begin
    same = (rd_ent.hash == carry_r.hash) && (rd_ent.ku == carry_r.ku)
           && (rd_ent.kl == carry_r.kl);
    cap  = ({1'b0, stored_r} >= {2'b0, key_limit})
           || ({{(32-CNT_W){1'b0}}, stored_r} >= 32'(SLOTS));
    od   = idx_r - rd_ent.hash[IDX_W-1:0];
    less = od < dist_r;
    last = (steps_r == STP_W'(SLOTS - 1));
    state_nxt   = state_r;
    carry_nxt   = carry_r;
    idx_nxt     = idx_r;
    dist_nxt    = dist_r;
    steps_nxt   = steps_r;
    swapped_nxt = swapped_r;
    stored_nxt  = stored_r;
    wr_en   = 1'b0;
    wr_used = 1'b0;
    wr_ent  = carry_r;
    fin     = 1'b0;
    res     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (req.valid && req.ready) begin
          carry_nxt   = req.data.ent;
          idx_nxt     = req.data.ent.hash[IDX_W-1:0];
          dist_nxt    = '0;
          steps_nxt   = '0;
          swapped_nxt = 1'b0;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (mode_r == MODE_LOOKUP) begin
          if (!rd_used || (!same && less)) begin
            fin = 1'b1; res.outcome = OUT_ABSENT;
          end else if (same) begin
            fin = 1'b1; res.outcome = OUT_FOUND;
            res.w0 = rd_ent.v0; res.w1 = rd_ent.v1; res.w2 = rd_ent.v2;
            res.w3 = rd_ent.v3; res.len = rd_ent.len;
          end else if (last) begin
            fin = 1'b1; res.outcome = OUT_ABSENT;
          end
        end else begin
          if (!rd_used) begin
            fin = 1'b1;
            if (!swapped_r && cap) begin
              res.outcome = OUT_FULL;
            end else begin
              wr_en = 1'b1; wr_used = 1'b1;
              stored_nxt = stored_r + 1'b1;
              res.outcome = OUT_INSERTED;
            end
          end else if (!swapped_r && same) begin
            fin = 1'b1; wr_en = 1'b1; wr_used = 1'b1;
            wr_ent = rd_ent;
            wr_ent.v0 = carry_r.v0; wr_ent.v1 = carry_r.v1;
            wr_ent.v2 = carry_r.v2; wr_ent.v3 = carry_r.v3;
            wr_ent.len = carry_r.len;
            res.outcome = OUT_UPDATED;
          end else if (less && !swapped_r && cap) begin
            fin = 1'b1; res.outcome = OUT_FULL;
          end else begin
            if (less) begin
              wr_en = 1'b1; wr_used = 1'b1;
              swapped_nxt = 1'b1;
              carry_nxt = rd_ent;
            end
            if (last) begin
              fin = 1'b1; res.outcome = OUT_FULL;
            end
          end
        end
        if (fin) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          dist_nxt  = (less && mode_r == MODE_INSERT ? od : dist_r) + 1'b1;
          steps_nxt = steps_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
      swapped_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stored_r  <= stored_nxt;
      swapped_r <= swapped_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    idx_r   <= idx_nxt;
    dist_r  <= dist_nxt;
    steps_r <= steps_nxt;
    if (state_r == ST_IDLE && req.valid && req.ready) begin
      mode_r <= req.data.mode;
    end
    if (fin) begin
      out_r <= res;
    end
  end

endmodule

// ===== rtl/robin_hood_hash_map_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash map
// Key-value table with linear probing and Robin Hood displacement.
// ----------------------------------------------------------------------------
// One request is processed at a time. After reset a clearing pass empties
// the table, and in_ch is not ready until it ends. Each probed slot takes a
// registered memory read, then a compare and write back, and a chain probes
// at most SLOTS slots; the result is held in an output register and the
// next request is taken the cycle after it transfers.
// key_limit sits at byte address 0 of the APB port.
module robin_hood_hash_map_top
  import rhhm_pkg::*;
#(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  rhhm_if.sink                in_ch,
  rhhm_if.source              out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [LIMIT_W-1:0] key_limit_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {22'b0, key_limit_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_limit_r <= KEY_LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) begin
      key_limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  rhhm_probe #(.SLOTS(SLOTS)) u_probe (
    .clk, .rst_n,
    .key_limit(key_limit_r),
    .req(in_ch),
    .rsp(out_ch)
  );

endmodule
